/* hw/rtl/thlc_pkg.sv */
// Package: shared types and codes for the turn and hazard lamp controller.
package thlc_pkg;

  // Opcodes of an input word
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Lamp function codes (also the bit index in the lamp vectors)
  localparam logic [2:0] LMP_LEFT  = 3'd0;
  localparam logic [2:0] LMP_RIGHT = 3'd1;
  localparam logic [2:0] LMP_HAZ   = 3'd2;
  localparam logic [2:0] LMP_PARK  = 3'd3;
  localparam logic [2:0] LMP_HEAD  = 3'd4;

  // Blink timer slots
  localparam logic [1:0] TMR_LEFT  = 2'd0;
  localparam logic [1:0] TMR_RIGHT = 2'd1;
  localparam logic [1:0] TMR_HAZ   = 2'd2;

  // Lamp action codes
  localparam logic [1:0] ACT_ON  = 2'd0;
  localparam logic [1:0] ACT_OFF = 2'd1;
  localparam logic [1:0] ACT_TOG = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BLINK_ON  = 1'b0;
  localparam logic CFG_BLINK_OFF = 1'b1;

  localparam logic [15:0] BLINK_MS_RESET = 16'd500;

  // Indicator remembered across a hazard period
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LEFT  = 2'd1,
    MEM_RIGHT = 2'd2
  } mem_ind_t;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  lamp_function;
    logic [1:0]  lamp_action;
    logic [15:0] command_sequence;
    logic [31:0] now_ms;
  } thlc_in_t;

  typedef struct packed {
    logic [4:0] lamp_states;
    logic [4:0] drive_outputs;
  } thlc_out_t;

  // Per-timer control for one processed word
  typedef struct packed {
    logic run;    // start or advance the timer
    logic clear;  // return the timer to idle
  } blink_ctl_t;

endpackage

/* hw/rtl/thlc_blink_timer.sv */
// Module: one blink phase timer with wrapping millisecond arithmetic.
module thlc_blink_timer (
  input  logic                clk,
  input  logic                rst,
  input  thlc_pkg::blink_ctl_t ctl,
  input  logic [31:0]         now_ms,
  input  logic [15:0]         on_ms,
  input  logic [15:0]         off_ms,
  output logic                phase
);
  import thlc_pkg::*;

  logic        lit;
  logic        lit_next;
  logic [31:0] phase_start;
  logic [31:0] phase_start_next;
  logic        running;
  logic [31:0] elapsed;
  logic [15:0] len;

  // Phase length and wrapping elapsed time
  assign len     = lit ? on_ms : off_ms;
  assign elapsed = now_ms - phase_start;

  // Run step: start in the lit phase, or flip once the phase has expired
  always_comb begin
    lit_next         = lit;
    phase_start_next = phase_start;
    if (!running) begin
      lit_next         = 1'b1;
      phase_start_next = now_ms;
    end else if (elapsed >= {16'd0, len}) begin
      lit_next         = ~lit;
      phase_start_next = now_ms;
    end
  end

  assign phase = lit_next;

  // Timer registers
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      lit         <= 1'b0;
      phase_start <= '0;
      running     <= 1'b0;
    end else if (ctl.run) begin
      lit         <= lit_next;
      phase_start <= phase_start_next;
      running     <= 1'b1;
    end
  end

endmodule

/* hw/rtl/thlc_lamp_ctrl.sv */
// Module: logical lamp states with hazard and indicator arbitration.
module thlc_lamp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  thlc_pkg::thlc_in_t word,
  output logic [4:0]         lamp_on,
  output logic [4:0]         lamp_on_next
);
  import thlc_pkg::*;

  logic [15:0] hazard_seq;
  logic [15:0] hazard_seq_next;
  mem_ind_t    remembered;
  mem_ind_t    remembered_next;

  // Command decode
  always_comb begin
    logic [1:0] act;
    logic       cur;
    mem_ind_t   mine;
    logic [2:0] other;

    lamp_on_next    = lamp_on;
    hazard_seq_next = hazard_seq;
    remembered_next = remembered;
    act   = word.lamp_action;
    cur   = 1'b0;
    mine  = (word.lamp_function == LMP_LEFT) ? MEM_LEFT : MEM_RIGHT;
    other = (word.lamp_function == LMP_LEFT) ? LMP_RIGHT : LMP_LEFT;

    if (word.opcode == OP_CMD) begin
      case (word.lamp_function) inside
        LMP_HAZ: begin
          // Hazard always toggles, action ignored
          hazard_seq_next = word.command_sequence;
          if (lamp_on[LMP_HAZ]) begin
            lamp_on_next[LMP_HAZ]   = 1'b0;
            lamp_on_next[LMP_LEFT]  = (remembered == MEM_LEFT);
            lamp_on_next[LMP_RIGHT] = (remembered == MEM_RIGHT);
            remembered_next = MEM_NONE;
          end else begin
            lamp_on_next[LMP_HAZ] = 1'b1;
            if (lamp_on[LMP_LEFT])       remembered_next = MEM_LEFT;
            else if (lamp_on[LMP_RIGHT]) remembered_next = MEM_RIGHT;
            else                         remembered_next = MEM_NONE;
          end
        end
        LMP_LEFT, LMP_RIGHT: begin
          // Dropped on a repeated hazard sequence or while hazard is on
          if (word.command_sequence != hazard_seq && !lamp_on[LMP_HAZ]) begin
            cur = lamp_on[word.lamp_function];
            if (act == ACT_TOG) act = cur ? ACT_OFF : ACT_ON;
            if (act == ACT_ON) begin
              remembered_next                   = mine;
              lamp_on_next[other]               = 1'b0;
              lamp_on_next[word.lamp_function]  = 1'b1;
            end else if (act == ACT_OFF) begin
              if (remembered == mine) remembered_next = MEM_NONE;
              lamp_on_next[word.lamp_function] = 1'b0;
            end
          end
        end
        LMP_PARK, LMP_HEAD: begin
          case (act)
            ACT_ON:  lamp_on_next[word.lamp_function] = 1'b1;
            ACT_OFF: lamp_on_next[word.lamp_function] = 1'b0;
            ACT_TOG: lamp_on_next[word.lamp_function] = ~lamp_on[word.lamp_function];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_on    <= '0;
      hazard_seq <= '0;
      remembered <= MEM_NONE;
    end else if (en) begin
      lamp_on    <= lamp_on_next;
      hazard_seq <= hazard_seq_next;
      remembered <= remembered_next;
    end
  end

endmodule

/* hw/rtl/turn_hazard_lamp_controller_top.sv */
// Turn and hazard lamp controller: input register, single-pass update, result register.
// A word held in the input register passes to the result register once that register is free.
// Throughput: one word per cycle; a waiting result holds the input once the input register
// is also full.
// Reset (synchronous): lamps off, hazard sequence zero, no remembered indicator,
// blink timers idle, drive pins low, both blink lengths back to 500 ms.
module turn_hazard_lamp_controller_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  thlc_pkg::thlc_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output thlc_pkg::thlc_out_t out_word,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import thlc_pkg::*;

  logic       in_q_valid;
  thlc_in_t   in_q;
  logic       advance;
  logic       is_tick;
  logic [15:0] blink_on_ms;
  logic [15:0] blink_off_ms;
  logic [4:0] lamp_on;
  logic [4:0] lamp_on_next;
  logic [4:0] drive_register;
  logic [4:0] drive_next;
  blink_ctl_t tmr_ctl [3];
  logic [2:0] tmr_phase;

  // Handshake: process the held word when the result register is free
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;
  assign is_tick  = (in_q.opcode == OP_TICK);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_word;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_on_ms  <= BLINK_MS_RESET;
      blink_off_ms <= BLINK_MS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BLINK_ON:  blink_on_ms  <= cfg_data;
        CFG_BLINK_OFF: blink_off_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lamp state
  thlc_lamp_ctrl u_lamp (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .word         (in_q),
    .lamp_on      (lamp_on),
    .lamp_on_next (lamp_on_next)
  );

  // Timer control: hazard timer runs while hazard is on, else indicators follow their lamps
  always_comb begin
    tmr_ctl[TMR_HAZ]   = '{run: 1'b0, clear: 1'b0};
    tmr_ctl[TMR_LEFT]  = '{run: 1'b0, clear: 1'b0};
    tmr_ctl[TMR_RIGHT] = '{run: 1'b0, clear: 1'b0};
    if (advance && is_tick) begin
      if (lamp_on[LMP_HAZ]) begin
        tmr_ctl[TMR_HAZ].run = 1'b1;
      end else begin
        tmr_ctl[TMR_HAZ].clear   = 1'b1;
        tmr_ctl[TMR_LEFT].run    = lamp_on[LMP_LEFT];
        tmr_ctl[TMR_LEFT].clear  = !lamp_on[LMP_LEFT];
        tmr_ctl[TMR_RIGHT].run   = lamp_on[LMP_RIGHT];
        tmr_ctl[TMR_RIGHT].clear = !lamp_on[LMP_RIGHT];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_tmr
    thlc_blink_timer u_tmr (
      .clk    (clk),
      .rst    (rst),
      .ctl    (tmr_ctl[k]),
      .now_ms (in_q.now_ms),
      .on_ms  (blink_on_ms),
      .off_ms (blink_off_ms),
      .phase  (tmr_phase[k])
    );
  end

  // Drive pins after blinking
  always_comb begin
    drive_next = '0;
    if (lamp_on[LMP_HAZ]) begin
      drive_next[LMP_LEFT]  = tmr_phase[TMR_HAZ];
      drive_next[LMP_RIGHT] = tmr_phase[TMR_HAZ];
      drive_next[LMP_HAZ]   = tmr_phase[TMR_HAZ];
    end else begin
      drive_next[LMP_LEFT]  = lamp_on[LMP_LEFT] && tmr_phase[TMR_LEFT];
      drive_next[LMP_RIGHT] = lamp_on[LMP_RIGHT] && tmr_phase[TMR_RIGHT];
    end
    drive_next[LMP_PARK] = lamp_on[LMP_PARK];
    drive_next[LMP_HEAD] = lamp_on[LMP_HEAD];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_register <= '0;
    end else if (advance && is_tick) begin
      drive_register <= drive_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word.lamp_states   <= lamp_on_next;
      out_word.drive_outputs <= is_tick ? drive_next : drive_register;
    end
  end

  // Both indicators are never on together
  a_one_indicator: assert property (@(posedge clk) disable iff (rst)
    !(lamp_on[LMP_LEFT] && lamp_on[LMP_RIGHT]))
    else $error("both indicators on");

  // Stalled input only when a word is held and the result register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_q_valid && out_valid && !out_ready))
    else $error("input stalled without cause");

  // Hazard tick drives left, right and hazard pins together
  a_hazard_pins: assert property (@(posedge clk) disable iff (rst)
    (advance && is_tick && lamp_on[LMP_HAZ]) |=>
      (drive_register[LMP_LEFT] == drive_register[LMP_HAZ]) &&
      (drive_register[LMP_RIGHT] == drive_register[LMP_HAZ]))
    else $error("hazard pins out of step");

  // Park and head pins copy their lamps after a tick
  a_steady_pins: assert property (@(posedge clk) disable iff (rst)
    (advance && is_tick) |=>
      (drive_register[LMP_PARK] == lamp_on[LMP_PARK]) &&
      (drive_register[LMP_HEAD] == lamp_on[LMP_HEAD]))
    else $error("park or head pin wrong");

endmodule
